/* rtl/crbi_pkg.sv */
package crbi_pkg;

  // default sizes of the index
  localparam int MaxRecordsDef = 64;
  localparam int MaxRunsDef    = 16;

  localparam int SecsPerMin = 60;

  // field widths
  localparam int KeyW  = 28;
  localparam int IdxW  = 12;
  localparam int BlkW  = 16;
  localparam int BbW   = 24;
  localparam int ByteW = 32;
  localparam int CntW  = 33;

  // shared divider widths
  localparam int DivW = 40;
  localparam int DvsW = 25;

  // reset values of the configuration registers
  localparam logic [BlkW-1:0] TotalRst = 16'hFFFF;
  localparam logic [BbW-1:0]  BbRst    = 24'h010000;

  // result status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StTooLarge = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CfgTotal = 2'd0;
  localparam logic [1:0] CfgBlock = 2'd1;

  typedef struct packed {
    logic             action;
    logic [KeyW-1:0]  key;
    logic [IdxW-1:0]  idx;
    logic [ByteW-1:0] bytes;
  } item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [BlkW-1:0] first;
    logic [BlkW-1:0] last;
    logic [IdxW-1:0] ci;
  } res_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
    logic [DvsW-1:0] rem;
  } div_rsp_t;

endpackage

/* rtl/crbi_div.sv */
module crbi_div import crbi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CW = $clog2(DivW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CW-1:0]   cnt_q;
  logic [DivW-1:0] num_q;
  logic [DvsW:0]   rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvsW:0]   trial;
  logic            ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q[DvsW-1:0], num_q[DivW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        num_q  <= req_i.dividend;
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
        cnt_q  <= CW'(DivW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        num_q <= {num_q[DivW-2:0], ge};
        rem_q <= ge ? (trial - {1'b0, dvs_q}) : trial;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q[DvsW-1:0];

endmodule

/* rtl/crbi_core.sv */
module crbi_core import crbi_pkg::*; #(
  parameter int MAX_RECORDS = MaxRecordsDef,
  parameter int MAX_RUNS    = MaxRunsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [BlkW-1:0] total_i,
  input  logic [BbW-1:0]  bb_i,
  input  logic            item_valid_i,
  input  item_t           item_i,
  output logic            busy_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output res_t            res_o,
  output div_req_t        div_req_o,
  input  div_rsp_t        div_rsp_i
);

  localparam int SW   = $clog2(MAX_RECORDS);
  localparam int NW   = $clog2(MAX_RECORDS + 1);
  localparam int RCW  = $clog2(MAX_RUNS + 1);
  localparam int RAW  = $clog2(MAX_RECORDS * MAX_RUNS);
  localparam int RDEP = MAX_RECORDS * MAX_RUNS;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_R_REQ  = 5'd1;
  localparam logic [4:0] S_R_CHK  = 5'd2;
  localparam logic [4:0] S_RR_REQ = 5'd3;
  localparam logic [4:0] S_RR_CHK = 5'd4;
  localparam logic [4:0] S_R_MUL  = 5'd5;
  localparam logic [4:0] S_R_ACC  = 5'd6;
  localparam logic [4:0] S_RF_MUL = 5'd7;
  localparam logic [4:0] S_RF_SUM = 5'd8;
  localparam logic [4:0] S_RF_DV1 = 5'd9;
  localparam logic [4:0] S_RF_DV2 = 5'd10;
  localparam logic [4:0] S_W_SIZ  = 5'd11;
  localparam logic [4:0] S_W_DIV  = 5'd12;
  localparam logic [4:0] S_W_FREE = 5'd13;
  localparam logic [4:0] S_W_FCHK = 5'd14;
  localparam logic [4:0] S_W_ST   = 5'd15;
  localparam logic [4:0] S_W_EN   = 5'd16;
  localparam logic [4:0] S_W_REQ  = 5'd17;
  localparam logic [4:0] S_W_CHK  = 5'd18;
  localparam logic [4:0] S_W_RREQ = 5'd19;
  localparam logic [4:0] S_W_RCHK = 5'd20;
  localparam logic [4:0] S_W_NEW  = 5'd21;
  localparam logic [4:0] S_W_FIN  = 5'd22;
  localparam logic [4:0] S_DONE   = 5'd23;

  // record and run stores
  logic [KeyW-1:0] key_mem [MAX_RECORDS];
  logic [IdxW-1:0] fs_mem  [MAX_RECORDS];
  logic [IdxW-1:0] ls_mem  [MAX_RECORDS];
  logic [BlkW-1:0] fb_mem  [MAX_RECORDS];
  logic [BlkW-1:0] lb_mem  [MAX_RECORDS];
  logic [RCW-1:0]  rc_mem  [MAX_RECORDS];
  logic [31:0]     run_mem [RDEP];

  logic [KeyW-1:0] rk_q;
  logic [IdxW-1:0] rfs_q, rls_q;
  logic [BlkW-1:0] rfb_q, rlb_q;
  logic [RCW-1:0]  rrc_q;
  logic [31:0]     run_q;

  logic [4:0]      state_q;
  item_t           item_q;
  logic [SW-1:0]   head_q, slot_q;
  logic [NW-1:0]   count_q, k_q;
  logic [BlkW-1:0] free_q, wp_q, st_q, en_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] id_q, ci_q;
  logic [RCW-1:0]  r_q, n_q;
  logic [DivW-1:0] off_q;
  logic [15:0]     mul_a_q, mul_b_q;
  logic [31:0]     prod_q;
  res_t            res_q;

  // shared helpers
  logic [BlkW-1:0] tsz;
  logic [SW-1:0]   next_slot, head_dec, head_inc, oldest;
  logic [NW:0]     old_x;
  logic            last_rec, rd_match, wr_match, id_hit, same_run;
  logic            runs_full, recs_full, need_free, no_free;
  logic [IdxW:0]   ls_inc;
  logic [15:0]     rep, rcnt;
  logic [16:0]     gain;
  logic [17:0]     nfree;
  logic [BlkW:0]   en_inc;

  assign tsz       = (total_i == '0) ? BlkW'(1) : total_i;
  assign next_slot = (slot_q == '0) ? SW'(MAX_RECORDS - 1) : slot_q - 1'b1;
  assign head_dec  = (head_q == '0) ? SW'(MAX_RECORDS - 1) : head_q - 1'b1;
  assign head_inc  = (head_q == SW'(MAX_RECORDS - 1)) ? '0 : head_q + 1'b1;
  assign old_x     = ((NW+1)'(head_q) >= (NW+1)'(count_q)) ?
                     (NW+1)'(head_q) - (NW+1)'(count_q) :
                     (NW+1)'(head_q) + (NW+1)'(MAX_RECORDS) - (NW+1)'(count_q);
  assign oldest    = old_x[SW-1:0];
  assign last_rec  = (k_q + 1'b1) == count_q;

  assign rd_match  = (rk_q == item_q.key) && (item_q.idx >= rfs_q) && (item_q.idx <= rls_q);
  assign ls_inc    = {1'b0, rls_q} + 1'b1;
  assign wr_match  = (rk_q == item_q.key) && ({1'b0, item_q.idx} == ls_inc);
  assign rep       = run_q[31:16];
  assign rcnt      = run_q[15:0];
  assign id_hit    = {4'b0, id_q} < rep;
  assign same_run  = (n_q != '0) && (rcnt == cnt_q[15:0]) && (cnt_q[CntW-1:16] == '0);
  assign runs_full = n_q >= RCW'(MAX_RUNS);
  assign recs_full = count_q == NW'(MAX_RECORDS);
  assign need_free = cnt_q > CntW'(free_q);
  assign no_free   = (free_q >= tsz) || (count_q == '0);

  // blocks given back by the oldest record, saturating
  assign gain  = (rlb_q >= rfb_q) ? (17'(rlb_q) - 17'(rfb_q) + 17'd1) :
                 (17'(tsz) + 17'(rlb_q) + 17'd1 - 17'(rfb_q));
  assign nfree = 18'(free_q) + 18'(gain);
  assign en_inc = {1'b0, en_q} + 1'b1;

  // store control
  logic            rec_rd_en, rec_new_we, rec_upd_we;
  logic [SW-1:0]   rec_rd_addr, rec_wr_addr;
  logic            run_rd_en, run_we;
  logic [RAW-1:0]  run_addr;
  logic [RAW-1:0]  run_slot;
  logic [RCW-1:0]  run_idx;
  logic [31:0]     run_wdata;

  always_comb begin
    rec_rd_en   = (state_q == S_R_REQ) || (state_q == S_W_REQ) ||
                  ((state_q == S_W_FREE) && need_free && !no_free);
    rec_rd_addr = (state_q == S_W_FREE) ? oldest : slot_q;
    rec_new_we  = (state_q == S_W_NEW) && !recs_full;
    rec_upd_we  = (state_q == S_W_RCHK) && (same_run || !runs_full);
    rec_wr_addr = (state_q == S_W_NEW) ? head_q : slot_q;

    run_rd_en = (state_q == S_RR_REQ) || (state_q == S_W_RREQ);
    run_we    = rec_new_we || rec_upd_we;
    run_slot  = (state_q == S_W_NEW) ? RAW'(head_q) : RAW'(slot_q);
    case (state_q)
      S_RR_REQ: run_idx = r_q;
      S_W_RREQ: run_idx = (n_q == '0) ? '0 : n_q - 1'b1;
      S_W_RCHK: run_idx = same_run ? n_q - 1'b1 : n_q;
      default:  run_idx = '0;
    endcase
    run_addr  = run_slot * RAW'(MAX_RUNS) + RAW'(run_idx);
    run_wdata = (rec_upd_we && same_run) ? (run_q + 32'h0001_0000) :
                {16'd1, cnt_q[15:0]};
  end

  always_ff @(posedge clk_i) begin
    if (rec_new_we) begin
      key_mem[rec_wr_addr] <= item_q.key;
      fs_mem[rec_wr_addr]  <= item_q.idx;
      ls_mem[rec_wr_addr]  <= item_q.idx;
      fb_mem[rec_wr_addr]  <= st_q;
      lb_mem[rec_wr_addr]  <= en_q;
      rc_mem[rec_wr_addr]  <= RCW'(1);
    end else if (rec_upd_we) begin
      ls_mem[rec_wr_addr] <= ls_inc[IdxW-1:0];
      lb_mem[rec_wr_addr] <= en_q;
      rc_mem[rec_wr_addr] <= same_run ? n_q : n_q + 1'b1;
    end
    if (rec_rd_en) begin
      rk_q  <= key_mem[rec_rd_addr];
      rfs_q <= fs_mem[rec_rd_addr];
      rls_q <= ls_mem[rec_rd_addr];
      rfb_q <= fb_mem[rec_rd_addr];
      rlb_q <= lb_mem[rec_rd_addr];
      rrc_q <= rc_mem[rec_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_we) begin
      run_mem[run_addr] <= run_wdata;
    end
    if (run_rd_en) begin
      run_q <= run_mem[run_addr];
    end
  end

  // divider requests
  always_comb begin
    div_req_o.start    = 1'b0;
    div_req_o.dividend = '0;
    div_req_o.divisor  = DvsW'(tsz);
    case (state_q)
      S_W_SIZ: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = DivW'(item_q.bytes);
        div_req_o.divisor  = DvsW'(bb_i) + 1'b1;
      end
      S_RF_SUM: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = off_q + DivW'(rfb_q) + DivW'(prod_q);
      end
      S_RF_DV1: begin
        div_req_o.start    = div_rsp_i.done;
        div_req_o.dividend = DivW'(div_rsp_i.rem) + DivW'(cnt_q) + DivW'(tsz) - 1'b1;
      end
      S_W_FREE: begin
        div_req_o.start    = !need_free;
        div_req_o.dividend = DivW'(wp_q);
      end
      S_W_ST: begin
        div_req_o.start    = div_rsp_i.done;
        div_req_o.dividend = DivW'(div_rsp_i.rem) + DivW'(cnt_q) - 1'b1;
      end
      default: begin
        div_req_o.start = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      free_q  <= TotalRst;
      wp_q    <= '0;
      item_q  <= '0;
      slot_q  <= '0;
      k_q     <= '0;
      st_q    <= '0;
      en_q    <= '0;
      cnt_q   <= '0;
      id_q    <= '0;
      ci_q    <= '0;
      r_q     <= '0;
      n_q     <= '0;
      off_q   <= '0;
      mul_a_q <= '0;
      mul_b_q <= '0;
      prod_q  <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            item_q <= item_i;
            k_q    <= '0;
            slot_q <= head_dec;
            if (item_i.action) begin
              state_q <= S_W_SIZ;
            end else if (count_q == '0) begin
              res_q   <= '{StNotFound, '0, '0, '0};
              state_q <= S_DONE;
            end else begin
              state_q <= S_R_REQ;
            end
          end
        end
        S_R_REQ: state_q <= S_R_CHK;
        S_R_CHK: begin
          if (rd_match && rrc_q != '0) begin
            id_q    <= item_q.idx - rfs_q;
            r_q     <= '0;
            n_q     <= rrc_q;
            off_q   <= '0;
            state_q <= S_RR_REQ;
          end else if (last_rec) begin
            res_q   <= '{StNotFound, '0, '0, '0};
            state_q <= S_DONE;
          end else begin
            k_q     <= k_q + 1'b1;
            slot_q  <= next_slot;
            state_q <= S_R_REQ;
          end
        end
        S_RR_REQ: state_q <= S_RR_CHK;
        S_RR_CHK: begin
          mul_b_q <= rcnt;
          if (id_hit) begin
            mul_a_q <= {4'b0, id_q};
            cnt_q   <= CntW'(rcnt);
            state_q <= S_RF_MUL;
          end else begin
            mul_a_q <= rep;
            id_q    <= id_q - rep[IdxW-1:0];
            state_q <= S_R_MUL;
          end
        end
        S_R_MUL: begin
          prod_q  <= mul_a_q * mul_b_q;
          state_q <= S_R_ACC;
        end
        S_R_ACC: begin
          off_q <= off_q + DivW'(prod_q);
          if ((r_q + 1'b1) != n_q) begin
            r_q     <= r_q + 1'b1;
            state_q <= S_RR_REQ;
          end else if (last_rec) begin
            res_q   <= '{StNotFound, '0, '0, '0};
            state_q <= S_DONE;
          end else begin
            k_q     <= k_q + 1'b1;
            slot_q  <= next_slot;
            state_q <= S_R_REQ;
          end
        end
        S_RF_MUL: begin
          prod_q  <= mul_a_q * mul_b_q;
          state_q <= S_RF_SUM;
        end
        S_RF_SUM: state_q <= S_RF_DV1;
        S_RF_DV1: begin
          if (div_rsp_i.done) begin
            st_q    <= div_rsp_i.rem[BlkW-1:0];
            state_q <= S_RF_DV2;
          end
        end
        S_RF_DV2: begin
          if (div_rsp_i.done) begin
            res_q   <= '{StOk, st_q, div_rsp_i.rem[BlkW-1:0], '0};
            state_q <= S_DONE;
          end
        end
        S_W_SIZ: state_q <= S_W_DIV;
        S_W_DIV: begin
          if (div_rsp_i.done) begin
            cnt_q   <= div_rsp_i.quot[CntW-1:0] + 1'b1;
            state_q <= S_W_FREE;
          end
        end
        S_W_FREE: begin
          if (!need_free) begin
            state_q <= S_W_ST;
          end else if (no_free) begin
            res_q   <= '{StTooLarge, '0, '0, '0};
            state_q <= S_DONE;
          end else begin
            state_q <= S_W_FCHK;
          end
        end
        S_W_FCHK: begin
          free_q  <= (nfree > 18'h0FFFF) ? 16'hFFFF : nfree[BlkW-1:0];
          count_q <= count_q - 1'b1;
          state_q <= S_W_FREE;
        end
        S_W_ST: begin
          if (div_rsp_i.done) begin
            st_q    <= div_rsp_i.rem[BlkW-1:0];
            state_q <= S_W_EN;
          end
        end
        S_W_EN: begin
          if (div_rsp_i.done) begin
            en_q    <= div_rsp_i.rem[BlkW-1:0];
            state_q <= (count_q == '0) ? S_W_NEW : S_W_REQ;
          end
        end
        S_W_REQ: state_q <= S_W_CHK;
        S_W_CHK: begin
          if (wr_match) begin
            n_q     <= rrc_q;
            state_q <= S_W_RREQ;
          end else if (last_rec) begin
            state_q <= S_W_NEW;
          end else begin
            k_q     <= k_q + 1'b1;
            slot_q  <= next_slot;
            state_q <= S_W_REQ;
          end
        end
        S_W_RREQ: state_q <= S_W_RCHK;
        S_W_RCHK: begin
          if (same_run || !runs_full) begin
            ci_q    <= ls_inc[IdxW-1:0];
            state_q <= S_W_FIN;
          end else begin
            res_q   <= '{StFull, '0, '0, '0};
            state_q <= S_DONE;
          end
        end
        S_W_NEW: begin
          if (recs_full) begin
            res_q   <= '{StFull, '0, '0, '0};
            state_q <= S_DONE;
          end else begin
            head_q  <= head_inc;
            count_q <= count_q + 1'b1;
            ci_q    <= item_q.idx;
            state_q <= S_W_FIN;
          end
        end
        S_W_FIN: begin
          wp_q    <= (en_inc == (BlkW+1)'(tsz)) ? '0 : en_inc[BlkW-1:0];
          free_q  <= free_q - cnt_q[BlkW-1:0];
          res_q   <= '{StOk, st_q, en_q, ci_q};
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = res_q;

endmodule

/* rtl/clip_ring_block_index.sv */
// Clip ring block index.
// Input channel (in_valid_i / in_stall_o) takes one request per transfer:
// action 1 stores a one-second clip of clip_bytes bytes at the given time,
// action 0 looks up the blocks of the clip stored for that time.
// Output channel (out_valid_o / out_stall_i) returns one result per request:
// status, first and last block in the ring, and the second index of a write.
// Configuration: cfg_we_i writes total_blocks (index 0) or block_bytes
// (index 1) from cfg_data_i; write only while no request is in flight.
// Flow: one request is in flight at a time and in_stall_o stays high until
// its result is handed to the output register. A read searches the records
// and steps through the runs of a matching record; on a hit it makes two
// divisions. A write makes three divisions (sizing and two ring modulos),
// frees the oldest records as needed and searches the records. The bit-serial
// divider is shared by all modulo steps.
// Reset empties the index, frees the whole ring and puts the write pointer
// at block 0. A stalled result holds in the output register; the block
// then finishes the next request and waits until the register is free.
module clip_ring_block_index import crbi_pkg::*; #(
  parameter int MAX_RECORDS = MaxRecordsDef,
  parameter int MAX_RUNS    = MaxRunsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [BbW-1:0]   cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             action_i,
  input  logic [13:0]      year_i,
  input  logic [3:0]       month_i,
  input  logic [4:0]       day_i,
  input  logic [4:0]       hour_i,
  input  logic [5:0]       minute_i,
  input  logic [5:0]       second_i,
  input  logic [ByteW-1:0] clip_bytes_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [BlkW-1:0]  first_block_o,
  output logic [BlkW-1:0]  last_block_o,
  output logic [IdxW-1:0]  clip_index_o
);

  logic [BlkW-1:0] total_q;
  logic [BbW-1:0]  bb_q;
  item_t           item;
  logic            busy;
  logic            res_valid, res_ready;
  res_t            res;
  res_t            out_q;
  logic            out_valid_q;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalRst;
      bb_q    <= BbRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTotal: total_q <= cfg_data_i[BlkW-1:0];
        CfgBlock: bb_q    <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // hour key and second index of the request
  assign item.action = action_i;
  assign item.key    = {year_i, month_i, day_i, hour_i};
  assign item.idx    = IdxW'(minute_i) * IdxW'(SecsPerMin) + IdxW'(second_i);
  assign item.bytes  = clip_bytes_i;

  crbi_core #(
    .MAX_RECORDS (MAX_RECORDS),
    .MAX_RUNS    (MAX_RUNS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .total_i      (total_q),
    .bb_i         (bb_q),
    .item_valid_i (in_valid_i),
    .item_i       (item),
    .busy_o       (busy),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp)
  );

  crbi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // output register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o    = busy;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign first_block_o = out_q.first;
  assign last_block_o  = out_q.last;
  assign clip_index_o  = out_q.ci;

endmodule

/* verif/clip_ring_block_index_tb.sv */
module clip_ring_block_index_tb;
  import crbi_pkg::*;

  localparam int NumRec = 64;
  localparam int NumRun = 16;
  localparam int IdleLimit = 50000;

  // register indexes outside the register list
  localparam logic [1:0] CfgSpareA = 2'd2;
  localparam logic [1:0] CfgSpareB = 2'd3;

  // one clip time and size as driven on the ports
  typedef struct {
    bit        action;
    bit [13:0] year;
    bit [3:0]  month;
    bit [4:0]  day;
    bit [4:0]  hour;
    bit [5:0]  minute;
    bit [5:0]  second;
    bit [31:0] bytes;
  } clip_req_t;

  // Index predictor with the queue of expected results
  class clip_index_board;
    int unsigned total_blocks, block_bytes;
    int unsigned date_key[NumRec], first_sec[NumRec], last_sec[NumRec];
    int unsigned first_blk[NumRec], last_blk[NumRec], run_cnt[NumRec];
    int unsigned runs[NumRec*NumRun];
    int unsigned head, live, free_blk, wr_ptr;
    res_t expected[$];
    int errors;

    function new();
      total_blocks = 65535; block_bytes = 65536;
      head = 0; live = 0; free_blk = 65535; wr_ptr = 0; errors = 0;
    endfunction

    function void set_reg(int idx, int unsigned val);
      if (idx == CfgTotal) total_blocks = val & 16'hFFFF;
      else if (idx == CfgBlock) block_bytes = val & 24'hFFFFFF;
    endfunction

    function int unsigned slot(int unsigned k);
      return (head + 2*NumRec - 1 - k) % NumRec;
    endfunction

    function void push(logic [1:0] st, longint fb, longint lb, longint ci);
      res_t r;
      r.status = st; r.first = fb[15:0]; r.last = lb[15:0]; r.ci = ci[11:0];
      expected = {expected, r};
    endfunction

    // work out the result of one accepted request
    function void note_request(clip_req_t q);
      int unsigned key, idx, s, n, p, lst;
      longint t, cnt, id, off, rep, rc, st, en, f, l, gain, nf;
      bit done;
      int unsigned ci;
      key = {4'd0, q.year, q.month, q.day, q.hour};
      idx = q.minute * 60 + q.second;
      t = (total_blocks == 0) ? 1 : total_blocks;
      if (!q.action) begin
        for (int k = 0; k < live; k++) begin
          s = slot(k);
          if (date_key[s] != key || idx < first_sec[s] || idx > last_sec[s]) continue;
          id = idx - first_sec[s];
          off = 0;
          n = run_cnt[s] > NumRun ? NumRun : run_cnt[s];
          for (int r = 0; r < n; r++) begin
            p = runs[s*NumRun + r];
            rep = p >> 16; rc = p & 16'hFFFF;
            if (id + 1 <= rep) begin
              st = (off + first_blk[s] + id * rc) % t;
              en = (st + rc + t - 1) % t;
              push(StOk, st, en, 0);
              return;
            end
            id -= rep;
            off += rep * rc;
          end
        end
        push(StNotFound, 0, 0, 0);
        return;
      end
      cnt = longint'(q.bytes) / (longint'(block_bytes) + 1) + 1;
      done = 0; ci = 0;
      // free the oldest records until the clip fits
      while (cnt > free_blk) begin
        if (free_blk >= t || live == 0) begin
          push(StTooLarge, 0, 0, 0);
          return;
        end
        s = slot(live - 1);
        f = first_blk[s]; l = last_blk[s];
        gain = (l >= f) ? (l - f + 1) : (t + l + 1 - f);
        nf = free_blk + gain;
        free_blk = nf > 65535 ? 65535 : 32'(nf);
        live--;
      end
      st = wr_ptr % t;
      en = (st + cnt - 1) % t;
      // try to extend a record of the same hour
      for (int k = 0; k < live; k++) begin
        s = slot(k);
        if (date_key[s] != key || idx != last_sec[s] + 1) continue;
        n = run_cnt[s];
        lst = (n == 0 || n > NumRun) ? 0 : runs[s*NumRun + n - 1];
        if (n != 0 && n <= NumRun && longint'(lst & 16'hFFFF) == cnt) begin
          runs[s*NumRun + n - 1] = lst + 32'h10000;
        end else begin
          if (n >= NumRun) begin
            push(StFull, 0, 0, 0);
            return;
          end
          runs[s*NumRun + n] = 32'((1 << 16) | (cnt & 16'hFFFF));
          run_cnt[s] = n + 1;
        end
        last_blk[s] = 32'(en);
        last_sec[s] = (last_sec[s] + 1) & 12'hFFF;
        ci = last_sec[s];
        done = 1;
        break;
      end
      if (!done) begin
        if (live >= NumRec) begin
          push(StFull, 0, 0, 0);
          return;
        end
        s = head % NumRec;
        date_key[s] = key; first_sec[s] = idx; last_sec[s] = idx;
        first_blk[s] = 32'(st); last_blk[s] = 32'(en); run_cnt[s] = 1;
        runs[s*NumRun] = 32'((1 << 16) | (cnt & 16'hFFFF));
        head = (head + 1) % NumRec;
        live++;
        ci = idx;
      end
      wr_ptr = 32'((en + 1) % t);
      free_blk -= 32'(cnt);
      push(StOk, st, en, ci);
    endfunction

    // compare one result transfer against the oldest expectation
    function void check_result(res_t got);
      res_t exp;
      if (expected.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      exp = expected[0];
      expected.delete(0);
      if (got.status !== exp.status) begin
        $error("status expected %0d got %0d", exp.status, got.status); errors++;
      end
      if (got.first !== exp.first) begin
        $error("first_block expected %0d got %0d", exp.first, got.first); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last_block expected %0d got %0d", exp.last, got.last); errors++;
      end
      if (got.ci !== exp.ci) begin
        $error("clip_index expected %0d got %0d", exp.ci, got.ci); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [BbW-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o, action_i;
  logic [13:0] year_i;
  logic [3:0] month_i;
  logic [4:0] day_i, hour_i;
  logic [5:0] minute_i, second_i;
  logic [ByteW-1:0] clip_bytes_i;
  logic out_valid_o, out_stall_i;
  logic [1:0] status_o;
  logic [BlkW-1:0] first_block_o, last_block_o;
  logic [IdxW-1:0] clip_index_o;

  clip_ring_block_index uut (.*);

  clip_index_board board = new();
  clip_req_t history[$];
  clip_req_t cur;
  int burst_left = 0;
  int idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result monitor
  always @(posedge clk_i) begin
    res_t r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      r.status = status_o; r.first = first_block_o;
      r.last = last_block_o; r.ci = clip_index_o;
      board.check_result(r);
    end
  end

  // receiver stall pattern: a random mode is held for a random span
  int stall_mode = 0, stall_cnt = 0;
  always @(negedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt = $urandom_range(50, 400);
    end
    stall_cnt--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 30);
      2: out_stall_i <= ($urandom_range(0, 99) < 80);
      default: out_stall_i <= (stall_cnt % 16) < 6;
    endcase
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(clip_req_t q);
    @(negedge clk_i);
    action_i <= q.action; year_i <= q.year; month_i <= q.month; day_i <= q.day;
    hour_i <= q.hour; minute_i <= q.minute; second_i <= q.second;
    clip_bytes_i <= q.bytes; in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(q);
    if (q.action) begin
      history = {history, q};
      if (history.size() > 256) history.delete(0);
    end
    // bursts with gaps between them
    if (burst_left == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
      burst_left = $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    // no request may be offered while the block drains
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val[23:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, val);
  endtask

  function automatic clip_req_t mk(bit a, int y, int mo, int d, int h, int mi, int s,
                                   longint b);
    clip_req_t q;
    q.action = a; q.year = 14'(y); q.month = 4'(mo); q.day = 5'(d); q.hour = 5'(h);
    q.minute = 6'(mi); q.second = 6'(s); q.bytes = b[31:0];
    return q;
  endfunction

  // bytes for a clip of roughly cnt blocks
  function automatic longint sized_bytes(int cnt);
    longint bb, v;
    bb = board.block_bytes;
    v = longint'(cnt - 1) * (bb + 1) + $urandom_range(0, board.block_bytes);
    return v > 64'hFFFFFFFF ? 64'hFFFFFFFF : v;
  endfunction

  task automatic random_phase(int n, int max_cnt);
    clip_req_t q;
    int r, c;
    c = 1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15 && cur.year != 0) begin
        // start a new hour
        cur = mk(1, $urandom_range(2000, 2003), $urandom_range(1, 12),
                 $urandom_range(1, 31), $urandom_range(0, 23),
                 $urandom_range(0, 59), $urandom_range(0, 59), 0);
      end
      if (r < 62) begin
        if ($urandom_range(0, 3) == 0) c = $urandom_range(1, max_cnt);
        q = cur; q.action = 1; q.bytes = 32'(sized_bytes(c));
        send(q);
        if (cur.second == 59) begin
          cur.second = 0;
          cur.minute = (cur.minute == 59) ? 6'd0 : 6'(cur.minute + 1);
        end else begin
          cur.second++;
        end
      end else if (r < 85 && history.size() != 0) begin
        q = history[$urandom_range(0, history.size() - 1)];
        q.action = 0; q.bytes = $urandom;
        send(q);
      end else if (r < 92) begin
        // read at arbitrary field values
        send(mk(0, $urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom));
      end else begin
        // write with arbitrary fields and size
        send(mk(1, $urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = CfgTotal; cfg_data_i = '0;
    in_valid_i = 1'b0; action_i = 1'b0; year_i = '0; month_i = '0; day_i = '0;
    hour_i = '0; minute_i = '0; second_i = '0; clip_bytes_i = '0; out_stall_i = 1'b0;
    cur = mk(1, 2001, 6, 15, 10, 0, 0, 0);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings
    send(mk(0, 2001, 6, 15, 10, 0, 0, 0));                     // empty index
    send(mk(1, 2001, 6, 15, 10, 0, 0, 0));                     // one block
    send(mk(1, 2001, 6, 15, 10, 0, 1, 65536));                 // same run
    send(mk(1, 2001, 6, 15, 10, 0, 2, 65537));                 // two blocks, new run
    send(mk(0, 2001, 6, 15, 10, 0, 1, 0));
    send(mk(0, 2001, 6, 15, 10, 0, 2, 0));
    send(mk(0, 2001, 6, 15, 10, 0, 3, 0));                     // past the end
    send(mk(1, 9999, 12, 31, 23, 59, 59, 32'hFFFFFFFF));       // too large
    send(mk(1, 0, 1, 1, 0, 0, 0, 1000));
    send(mk(1, 16383, 15, 31, 31, 63, 63, 5));                 // out-of-range time
    send(mk(0, 16383, 15, 31, 31, 63, 63, 0));
    send(mk(0, 2001, 6, 15, 10, 0, 0, 0));                     // freed by too large?
    // run table full: alternating sizes at block_bytes of one
    write_reg(CfgBlock, 1);
    for (int s = 0; s < 18; s++) send(mk(1, 2020, 2, 2, 2, 0, s, (s % 2) * 2));
    send(mk(0, 2020, 2, 2, 2, 0, 15, 0));
    write_reg(CfgSpareA, 7);                                   // ignored index
    write_reg(CfgSpareB, 9);

    random_phase(260, 3);
    write_reg(CfgTotal, 1); write_reg(CfgBlock, 16777215);
    random_phase(200, 2);
    write_reg(CfgTotal, 100); write_reg(CfgBlock, 1000);
    random_phase(260, 4);
    write_reg(CfgTotal, 0); write_reg(CfgBlock, 1);
    random_phase(150, 2);
    write_reg(CfgTotal, 65535); write_reg(CfgBlock, 16777215);
    random_phase(260, 4);
    write_reg(CfgTotal, 37); write_reg(CfgBlock, 1);
    random_phase(200, 6);
    write_reg(CfgTotal, 65535); write_reg(CfgBlock, 65536);
    random_phase(200, 3);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.expected.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.expected.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/crbi_pkg.sv
rtl/crbi_div.sv
rtl/crbi_core.sv
rtl/clip_ring_block_index.sv
verif/clip_ring_block_index_tb.sv
